// File: hw/rtl/xotm_pkg.sv
// Package for the XML open tag matcher: widths, character codes,
// configuration register indexes and the scan mode type.
// No dependencies.
`default_nettype none

package xotm_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_NAME_CHARS_DEF = 8;
  localparam int NUM_NAMES_DEF      = 4;

  // Configuration register layout
  localparam int NAME_REGS   = 4;
  localparam int NAME_W      = 64;
  localparam int NAME_SEL_W  = 2;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CHAR_W      = 8;
  localparam int CHAR_SEL_W  = 3;
  localparam int TAG_INDEX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TAG_COUNT = 3'd4;
  localparam logic [COUNT_W-1:0]   COUNT_RESET   = 3'd1;

  // Characters that steer the scan
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    MODE_SEEK,   // looking for '<'
    MODE_FIRST,  // first byte after '<'
    MODE_NAME,   // inside a tag name
    MODE_WAIT    // name matched, waiting for '>'
  } scan_mode_t;

endpackage

`default_nettype wire

// File: hw/rtl/xml_open_tag_matcher.sv
// XML open tag matcher top level: byte scanner, name compare lanes and
// result register. Depends on xotm_pkg.
`default_nettype none

// Takes XML text one byte per item and reports, on the '>' that closes an
// opening tag, which of the first tag_count configured names (eight
// characters at most, first character in the low byte, zero padded) the tag
// name equals exactly; the lowest index wins. Closing tags are skipped. An
// item flagged final that reports no match gives a not-found result, and
// the scan starts afresh after every final item. The block takes one item
// per cycle unless a waiting result is not taken; each item passes an input
// register and then the result register, so a result is loaded at the clock
// edge after its item is accepted and is valid from then on, unless a
// waiting result holds it back. The scan state updates as each item leaves
// the input register (one character compare per name lane), which sets that
// rate. Write the configuration registers only while no item is in flight.
module xml_open_tag_matcher #(
  parameter int MAX_NAME_CHARS = xotm_pkg::MAX_NAME_CHARS_DEF,
  parameter int NUM_NAMES      = xotm_pkg::NUM_NAMES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [xotm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [xotm_pkg::NAME_W-1:0]        cfg_wdata,
  // text input
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [xotm_pkg::CHAR_W-1:0]        in_text_byte,
  input  wire logic                               in_final_byte,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_found,
  output logic [xotm_pkg::TAG_INDEX_W-1:0]        out_tag_index
);

  localparam int POS_W = $clog2(MAX_NAME_CHARS + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_NAME_CHARS);

  // Configuration registers
  logic [xotm_pkg::NAME_W-1:0]  names_r [xotm_pkg::NAME_REGS];
  logic [xotm_pkg::COUNT_W-1:0] count_r;

  // Input register
  logic                         s1_valid_r;
  logic [xotm_pkg::CHAR_W-1:0]  s1_byte_r;
  logic                         s1_last_r;
  logic                         s1_adv;

  // Scan state
  xotm_pkg::scan_mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic [NUM_NAMES-1:0]             match_r, match_nxt;
  logic [xotm_pkg::TAG_INDEX_W-1:0] win_r, win_nxt;

  // Result register
  logic                             out_valid_r;
  logic                             out_found_r;
  logic [xotm_pkg::TAG_INDEX_W-1:0] out_tag_index_r;

  // Lane compare signals
  logic [POS_W-1:0]                 cmp_pos;
  logic [xotm_pkg::CHAR_SEL_W-1:0]  char_sel;
  logic                             pos_full;
  logic [POS_W-1:0]                 pos_inc;
  logic [NUM_NAMES-1:0]             lane_act;
  logic [NUM_NAMES-1:0]             lane_keep;
  logic [NUM_NAMES-1:0]             lane_end;
  logic                             end_ok;
  logic [xotm_pkg::TAG_INDEX_W-1:0] end_idx;
  logic                             hit;
  logic [xotm_pkg::TAG_INDEX_W-1:0] hit_idx;
  logic                             emit;
  logic                             is_sep;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xotm_pkg::NAME_REGS; i++) begin
        names_r[i] <= '0;
      end
      count_r <= xotm_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index < xotm_pkg::CFG_IDX_W'(xotm_pkg::NAME_REGS)) begin
        names_r[cfg_index[xotm_pkg::NAME_SEL_W-1:0]] <= cfg_wdata;
      end else if (cfg_index == xotm_pkg::REG_TAG_COUNT) begin
        count_r <= cfg_wdata[xotm_pkg::COUNT_W-1:0];
      end
    end
  end

  // Handshake: advance the input register when the result slot is free or being read
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_final_byte;
    end
  end

  // Character position under compare: zero on the first name byte
  assign cmp_pos  = (mode_r == xotm_pkg::MODE_FIRST) ? '0 : pos_r;
  assign char_sel = xotm_pkg::CHAR_SEL_W'(cmp_pos);
  assign pos_full = (cmp_pos >= POS_MAX);
  assign pos_inc  = pos_full ? cmp_pos : cmp_pos + POS_W'(1);

  // One compare lane per name; lanes without a register hold an empty name
  for (genvar j = 0; j < NUM_NAMES; j++) begin : g_lane
    logic [xotm_pkg::CHAR_W-1:0] lane_ch;
    if (j < xotm_pkg::NAME_REGS) begin : g_reg
      assign lane_ch =
        names_r[j][{char_sel, 3'b000} +: xotm_pkg::CHAR_W];
    end else begin : g_empty
      assign lane_ch = xotm_pkg::CH_NUL;
    end
    assign lane_act[j]  = (count_r > xotm_pkg::COUNT_W'(j));
    assign lane_keep[j] = !pos_full && (s1_byte_r != xotm_pkg::CH_NUL)
                          && (lane_ch == s1_byte_r);
    assign lane_end[j]  = match_r[j] && (pos_full || lane_ch == xotm_pkg::CH_NUL);
  end

  // Pick the lowest lane whose name ends here
  always_comb begin
    end_idx = '0;
    for (int j = NUM_NAMES - 1; j >= 0; j--) begin
      if (lane_end[j]) begin
        end_idx = xotm_pkg::TAG_INDEX_W'(j);
      end
    end
    end_ok = (|lane_end) && (pos_r != '0);
  end

  assign is_sep = (s1_byte_r == xotm_pkg::CH_SPACE) || (s1_byte_r == xotm_pkg::CH_GT);

  // Scan state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= xotm_pkg::MODE_SEEK;
      pos_r   <= '0;
      match_r <= '0;
      win_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      win_r   <= win_nxt;
    end
  end

  // Next scan state and result for the item in the input register
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    win_nxt   = win_r;
    hit       = 1'b0;
    hit_idx   = '0;
    if (s1_adv) begin
      case (mode_r)
        xotm_pkg::MODE_SEEK: begin
          if (s1_byte_r == xotm_pkg::CH_LT) begin
            mode_nxt = xotm_pkg::MODE_FIRST;
          end
        end
        xotm_pkg::MODE_FIRST: begin
          if (is_sep || s1_byte_r == xotm_pkg::CH_SLASH) begin
            mode_nxt = xotm_pkg::MODE_SEEK;
          end else begin
            match_nxt = lane_act & lane_keep;
            pos_nxt   = pos_inc;
            mode_nxt  = xotm_pkg::MODE_NAME;
          end
        end
        xotm_pkg::MODE_NAME: begin
          if (is_sep) begin
            if (!end_ok) begin
              mode_nxt = xotm_pkg::MODE_SEEK;
            end else if (s1_byte_r == xotm_pkg::CH_GT) begin
              hit      = 1'b1;
              hit_idx  = end_idx;
              mode_nxt = xotm_pkg::MODE_SEEK;
            end else begin
              win_nxt  = end_idx;
              mode_nxt = xotm_pkg::MODE_WAIT;
            end
          end else begin
            match_nxt = match_r & lane_keep;
            pos_nxt   = pos_inc;
          end
        end
        xotm_pkg::MODE_WAIT: begin
          if (s1_byte_r == xotm_pkg::CH_GT) begin
            hit      = 1'b1;
            hit_idx  = win_r;
            mode_nxt = xotm_pkg::MODE_SEEK;
          end
        end
        default: begin
          mode_nxt = xotm_pkg::MODE_SEEK;
        end
      endcase
      // Drop all scan state after the last byte of a text
      if (s1_last_r) begin
        mode_nxt  = xotm_pkg::MODE_SEEK;
        pos_nxt   = '0;
        match_nxt = '0;
        win_nxt   = '0;
      end
    end
  end

  assign emit = hit || s1_last_r;

  // Result register: load on a reporting item, clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_found_r     <= hit;
      out_tag_index_r <= hit_idx;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_tag_index = out_tag_index_r;

`ifndef SYNTH
  // A not-found result always carries index zero
  a_notfound_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_tag_index_r == '0)
    else $error("not-found result with nonzero index");

  // Name position never passes the name limit
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("name position beyond limit");

  // A stalled result holds the item in the input register
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input item lost under stall");

  // The last byte of a text leaves a clean scan state
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> mode_r == xotm_pkg::MODE_SEEK && match_r == '0
      && pos_r == '0)
    else $error("scan state not cleared after last byte");
`endif

endmodule

`default_nettype wire
